[rtl/range_max_segment_tree_top_assert.svh]
// ----------------------------------------------------------------------------
// range_max_segment_tree_top_assert.svh
// Assertion macros shared by the range-maximum tree RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define RMST_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// When the trigger holds, the consequence must hold in the same cycle.
`define RMST_ASSERT_SAME(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("same-cycle implication violated");

// When the trigger holds, the consequence must hold in the next cycle.
`define RMST_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[rtl/rmst_pkg.sv]
// ----------------------------------------------------------------------------
// rmst_pkg
// Types, constants and helper functions of the range-maximum tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

	localparam int DATA_W          = 64;
	localparam int REQ_W           = 2;
	localparam int INDEX_W         = 10;
	localparam int END_W           = 11;
	localparam int CFG_W           = 11;
	localparam int MAX_LEAVES_DEF  = 1024;

	localparam logic [CFG_W-1:0]         LEAF_COUNT_RST = 11'd1024;
	localparam logic signed [DATA_W-1:0] NEUTRAL        = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD    = 2'd0,
		REQ_REBUILD = 2'd1,
		REQ_UPDATE  = 2'd2,
		REQ_QUERY   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MRD,
		ST_MWR,
		ST_QRUN,
		ST_QDRAIN,
		ST_OUT
	} state_t;

	function automatic logic signed [DATA_W-1:0] smax(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		return (a >= b) ? a : b;
	endfunction

endpackage

[rtl/range_max_segment_tree_top.sv]
// ----------------------------------------------------------------------------
// range_max_segment_tree_top
// Load writes one leaf; rebuild merges nodes n-1 down to 1, and an update
// walks from the leaf to the root (read both children, then write the parent).
// A query reads two nodes per level from the dual-read tree memory, then
// drains and presents the result; one request is in flight at a time.
// Reset and every leaf_count write start a clearing pass over all 2*MAX_LEAVES
// nodes that sets them to the most negative value; no request is taken.
// ----------------------------------------------------------------------------
module range_max_segment_tree_top #(
	parameter int MAX_LEAVES = rmst_pkg::MAX_LEAVES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rmst_pkg::CFG_W-1:0]        leaf_count,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rmst_pkg::REQ_W-1:0]        req_type,
	input  logic [rmst_pkg::INDEX_W-1:0]      index,
	input  logic [rmst_pkg::END_W-1:0]        right_end,
	input  logic signed [rmst_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [rmst_pkg::DATA_W-1:0] range_max,
	output logic                              range_empty
);

	localparam int DEPTH    = 2 * MAX_LEAVES;
	localparam int NODE_W   = $clog2(DEPTH);
	localparam int AW       = NODE_W + 1;
	localparam int CNT_W    = $clog2(MAX_LEAVES + 1);
	localparam logic [NODE_W-1:0] CLR_LAST = NODE_W'(DEPTH - 1);

	rmst_pkg::state_t state_q, state_d;
	rmst_pkg::req_t   req;

	logic [rmst_pkg::CFG_W-1:0] leaf_count_q;
	logic [NODE_W-1:0]          clr_q;
	logic [NODE_W-1:0]          p_q;
	logic [NODE_W-1:0]          p_nx;
	logic                       rebuild_q;
	logic [AW-1:0]              l_q, r_q, l_nx, r_nx, r_m1;
	logic                       v_s1, fl_s1, fr_s1;
	logic signed [rmst_pkg::DATA_W-1:0] acc_q;
	logic                       qempty_q;
	logic                       out_valid_q;
	logic signed [rmst_pkg::DATA_W-1:0] range_max_q;
	logic                       range_empty_q;

	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  rend_c;
	logic              idx_ok;
	logic              q_empty;
	logic [NODE_W-1:0] leaf_addr;
	logic [AW-1:0]     l0, r0;
	logic              accept;
	logic              out_load;

	logic                               mem_we;
	logic [NODE_W-1:0]                  mem_wa;
	logic signed [rmst_pkg::DATA_W-1:0] mem_wd;
	logic [NODE_W-1:0]                  rd_a0, rd_a1;
	logic signed [rmst_pkg::DATA_W-1:0] rd0_q, rd1_q;
	logic signed [rmst_pkg::DATA_W-1:0] tree_mem [DEPTH];

	logic signed [rmst_pkg::DATA_W-1:0] cand_l, cand_r;
	logic signed [rmst_pkg::DATA_W-1:0] acc_nx;
	logic                               ge_al, ge_ar, ge_lr;

	// Tree storage: one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_wa] <= mem_wd;
		end
		rd0_q <= tree_mem[rd_a0];
		rd1_q <= tree_mem[rd_a1];
	end

	// Effective leaf count: zero acts as one, large values saturate.
	always_comb begin
		if (leaf_count_q == '0) begin
			n = CNT_W'(1);
		end else if (32'(leaf_count_q) > 32'(MAX_LEAVES)) begin
			n = CNT_W'(MAX_LEAVES);
		end else begin
			n = CNT_W'(leaf_count_q);
		end
		if (32'(right_end) > 32'(n)) begin
			rend_c = n;
		end else begin
			rend_c = CNT_W'(right_end);
		end
	end

	assign req       = rmst_pkg::req_t'(req_type);
	assign idx_ok    = 32'(index) < 32'(n);
	assign q_empty   = 32'(index) >= 32'(rend_c);
	assign leaf_addr = NODE_W'(32'(index) + 32'(n));
	assign l0        = AW'(32'(index) + 32'(n));
	assign r0        = AW'(32'(rend_c) + 32'(n));
	assign accept    = in_valid && in_ready;

	// Query walk: an odd left bound contributes and moves right, an odd
	// right bound contributes its left neighbor; both then climb a level.
	assign r_m1 = r_q - AW'(1);
	assign l_nx = (l_q + AW'(l_q[0])) >> 1;
	assign r_nx = r_q >> 1;
	assign p_nx = rebuild_q ? (p_q - NODE_W'(1)) : (p_q >> 1);

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = rmst_pkg::NEUTRAL;
		rd_a0    = '0;
		rd_a1    = '0;
		unique case (state_q)
			rmst_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == CLR_LAST) begin
					state_d = rmst_pkg::ST_IDLE;
				end
			end
			rmst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (req)
						rmst_pkg::REQ_LOAD: begin
							if (idx_ok) begin
								mem_we = 1'b1;
								mem_wa = leaf_addr;
								mem_wd = value;
							end
						end
						rmst_pkg::REQ_REBUILD: begin
							if (n > CNT_W'(1)) begin
								state_d = rmst_pkg::ST_MRD;
							end
						end
						rmst_pkg::REQ_UPDATE: begin
							if (idx_ok) begin
								mem_we = 1'b1;
								mem_wa = leaf_addr;
								mem_wd = value;
								if ((leaf_addr >> 1) != '0) begin
									state_d = rmst_pkg::ST_MRD;
								end
							end
						end
						rmst_pkg::REQ_QUERY: begin
							state_d = q_empty ? rmst_pkg::ST_OUT : rmst_pkg::ST_QRUN;
						end
					endcase
				end
			end
			rmst_pkg::ST_MRD: begin
				rd_a0   = {p_q[NODE_W-2:0], 1'b0};
				rd_a1   = {p_q[NODE_W-2:0], 1'b1};
				state_d = rmst_pkg::ST_MWR;
			end
			rmst_pkg::ST_MWR: begin
				mem_we  = 1'b1;
				mem_wa  = p_q;
				mem_wd  = rmst_pkg::smax(rd0_q, rd1_q);
				state_d = (p_nx == '0) ? rmst_pkg::ST_IDLE : rmst_pkg::ST_MRD;
			end
			rmst_pkg::ST_QRUN: begin
				rd_a0 = l_q[NODE_W-1:0];
				rd_a1 = r_m1[NODE_W-1:0];
				if (!(l_nx < r_nx)) begin
					state_d = rmst_pkg::ST_QDRAIN;
				end
			end
			rmst_pkg::ST_QDRAIN: begin
				state_d = rmst_pkg::ST_OUT;
			end
			rmst_pkg::ST_OUT: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = rmst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmst_pkg::ST_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_d = rmst_pkg::ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rmst_pkg::ST_CLEAR;
			leaf_count_q <= rmst_pkg::LEAF_COUNT_RST;
			clr_q        <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == rmst_pkg::ST_QRUN);
			if (cfg_we) begin
				leaf_count_q <= leaf_count;
				clr_q        <= '0;
			end else if (state_q == rmst_pkg::ST_CLEAR) begin
				clr_q <= clr_q + NODE_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The accumulator takes the larger of itself and the two nodes read.
	assign cand_l = fl_s1 ? rd0_q : rmst_pkg::NEUTRAL;
	assign cand_r = fr_s1 ? rd1_q : rmst_pkg::NEUTRAL;
	assign ge_al  = acc_q >= cand_l;
	assign ge_ar  = acc_q >= cand_r;
	assign ge_lr  = cand_l >= cand_r;

	always_comb begin
		if (ge_al && ge_ar) begin
			acc_nx = acc_q;
		end else if (ge_lr) begin
			acc_nx = cand_l;
		end else begin
			acc_nx = cand_r;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rebuild_q <= (req == rmst_pkg::REQ_REBUILD);
			p_q       <= (req == rmst_pkg::REQ_REBUILD) ? NODE_W'(n - CNT_W'(1))
			                                            : (leaf_addr >> 1);
			l_q       <= l0;
			r_q       <= r0;
			acc_q     <= rmst_pkg::NEUTRAL;
			qempty_q  <= q_empty;
		end else begin
			if (state_q == rmst_pkg::ST_MWR) begin
				p_q <= p_nx;
			end
			if (state_q == rmst_pkg::ST_QRUN) begin
				l_q <= l_nx;
				r_q <= r_nx;
			end
			if (v_s1) begin
				acc_q <= acc_nx;
			end
		end
		fl_s1 <= l_q[0];
		fr_s1 <= r_q[0];
		if (out_load) begin
			range_max_q   <= acc_q;
			range_empty_q <= qempty_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign range_max   = range_max_q;
	assign range_empty = range_empty_q;

	`include "range_max_segment_tree_top_assert.svh"

	`RMST_ASSERT_SAME(a_qrun_bounds, clk, arst_n, state_q == rmst_pkg::ST_QRUN, l_q < r_q)
	`RMST_ASSERT_SAME(a_merge_node, clk, arst_n,
		state_q == rmst_pkg::ST_MRD || state_q == rmst_pkg::ST_MWR, p_q != '0)
	`RMST_ASSERT_NEXT(a_read_then_write, clk, arst_n,
		state_q == rmst_pkg::ST_MRD && !cfg_we, state_q == rmst_pkg::ST_MWR)
	`RMST_ASSERT_ALWAYS(a_acc_in_query, clk, arst_n,
		!v_s1 || state_q == rmst_pkg::ST_QRUN || state_q == rmst_pkg::ST_QDRAIN
		|| state_q == rmst_pkg::ST_CLEAR)

endmodule
